@@ rtl/fsim_pkg.sv @@
// Shared types and constants for the floppy sector interleave mapper.
// No dependencies; every other file imports this package.
package fsim_pkg;

  localparam int SECTOR_BYTES = 128;
  localparam int MAX_SECTORS  = 64;
  localparam int CFG_W        = 12;
  localparam int SEC_W        = 14;
  localparam int DIV_W        = 20;
  localparam int DIV_CNT_W    = 5;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SPT    = 3'd0,
    REG_SPB    = 3'd1,
    REG_TSEC   = 3'd2,
    REG_TBLK   = 3'd3,
    REG_INC    = 3'd4,
    REG_IL     = 3'd5,
    REG_SKEW   = 3'd6,
    REG_OFFSET = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [9:0]  block_number;
    logic [13:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [6:0] track;
    logic [5:0] phys_sector;
    logic       last;
    logic       error;
  } res_t;

  typedef struct packed {
    logic [5:0]  sectors_per_track;
    logic [3:0]  sectors_per_block;
    logic [11:0] total_sectors;
    logic [9:0]  total_blocks;
    logic [5:0]  sector_increment;
    logic [5:0]  interleave;
    logic [5:0]  track_skew;
    logic [1:0]  track_offset;
  } cfg_t;

  // One sector job queued between front and back
  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic             last;
    logic             error;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [5:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [5:0]       rem;
  } div_rsp_t;

endpackage

@@ rtl/fsim_front.sv @@
// Front end: takes a request, checks the block number and expands the run
// into one queued job per sector. Depends on fsim_pkg.
module fsim_front import fsim_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  req_t req,
  input  cfg_t cfg,
  input  logic q_full,
  output logic q_push,
  output job_t q_job,
  output logic busy
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_RUN  = 2'b10
  } fstate_t;

  fstate_t          state_r, state_nxt;
  logic [SEC_W-1:0] sec_r, sec_nxt;
  logic [13:0]      bytes_r, bytes_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             err_r, err_nxt;
  logic [13:0]      bytes_left;
  logic             more;

  // Bytes left once the current sector is taken, and whether the run goes on
  always_comb begin
    bytes_left = (bytes_r > 14'(SECTOR_BYTES)) ? bytes_r - 14'(SECTOR_BYTES) : 14'd0;
    more = (bytes_left != 14'd0) &&
           ((sec_r + SEC_W'(1)) < {2'b00, cfg.total_sectors}) &&
           (cnt_r != 6'(MAX_SECTORS - 1));
  end

  // Issue one sector job per cycle while the queue has room
  always_comb begin
    state_nxt = state_r;
    sec_nxt   = sec_r;
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    q_push    = 1'b0;
    q_job     = '{sector: sec_r, last: !more || err_r, error: err_r};
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_RUN;
          err_nxt   = (req.block_number >= cfg.total_blocks);
          sec_nxt   = {4'b0, req.block_number} * {10'b0, cfg.sectors_per_block};
          bytes_nxt = req.byte_count;
          cnt_nxt   = 6'd0;
        end
      end
      F_RUN: begin
        if (!q_full) begin
          q_push = 1'b1;
          if (err_r || !more) begin
            state_nxt = F_IDLE;
          end else begin
            sec_nxt   = sec_r + SEC_W'(1);
            bytes_nxt = bytes_left;
            cnt_nxt   = cnt_r + 6'd1;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    sec_r   <= sec_nxt;
    bytes_r <= bytes_nxt;
    cnt_r   <= cnt_nxt;
    err_r   <= err_nxt;
  end

  assign busy = (state_r == F_RUN);

endmodule

@@ rtl/fsim_fifo.sv @@
// Short job queue between the front and back ends.
// Depends on fsim_pkg.
module fsim_fifo import fsim_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign full    = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/fsim_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, shared by the
// back end for track, group and sector reductions. Depends on fsim_pkg.
module fsim_div import fsim_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]     q_r;
  logic [5:0]           r_r;
  logic [5:0]           dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 act_r;
  logic                 done_r;
  logic [6:0]           trial;
  logic                 ge;

  // Trial subtract of the next partial remainder
  always_comb begin
    trial = {r_r, q_r[DIV_W-1]};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      r_r   <= 6'd0;
      dvs_r <= req.divisor;
    end else if (act_r) begin
      q_r <= {q_r[DIV_W-2:0], ge};
      r_r <= ge ? 6'(trial - {1'b0, dvs_r}) : trial[5:0];
    end
  end

  // Count steps and flag completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        act_r <= 1'b1;
        cnt_r <= DIV_CNT_W'(DIV_W);
      end else if (act_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_r, quot: q_r, rem: r_r};

endmodule

@@ rtl/fsim_back.sv @@
// Back end: pops sector jobs and maps each to a physical track and sector
// with the shared divider. Depends on fsim_pkg and fsim_div.
module fsim_back import fsim_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_empty,
  input  job_t q_job,
  output logic q_pop,
  output logic out_valid,
  output res_t out_res,
  output logic busy
);

  typedef enum logic [4:0] {
    B_IDLE    = 5'b00001,
    B_DIV_TRK = 5'b00010,
    B_DIV_IL  = 5'b00100,
    B_SUM     = 5'b01000,
    B_DIV_SEC = 5'b10000
  } bstate_t;

  bstate_t          state_r, state_nxt;
  div_req_t         div_req_r, div_req_nxt;
  div_rsp_t         div_rsp;
  logic [SEC_W-1:0] trk_r, trk_nxt;
  logic             last_r, last_nxt;
  logic [12:0]      grp_r, grp_nxt;
  logic [DIV_W-1:0] skw_r, skw_nxt;
  logic             vld_r, vld_nxt;
  res_t             res_r, res_nxt;
  logic [5:0]       spt_eff, il_eff;

  // Zero modulus or interleave acts as one
  assign spt_eff = (cfg.sectors_per_track == 6'd0) ? 6'd1 : cfg.sectors_per_track;
  assign il_eff  = (cfg.interleave == 6'd0) ? 6'd1 : cfg.interleave;

  fsim_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  // Sequence divide, multiply and reduce steps for one sector, or pass an error job straight to a result
  always_comb begin
    state_nxt   = state_r;
    div_req_nxt = '{start: 1'b0, dividend: div_req_r.dividend, divisor: div_req_r.divisor};
    trk_nxt     = trk_r;
    last_nxt    = last_r;
    grp_nxt     = grp_r;
    skw_nxt     = skw_r;
    vld_nxt     = 1'b0;
    res_nxt     = res_r;
    q_pop       = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_job.error) begin
            vld_nxt = 1'b1;
            res_nxt = '{track: 7'd0, phys_sector: 6'd0, last: 1'b1, error: 1'b1};
          end else begin
            last_nxt    = q_job.last;
            div_req_nxt = '{start: 1'b1, dividend: DIV_W'(q_job.sector), divisor: spt_eff};
            state_nxt   = B_DIV_TRK;
          end
        end
      end
      B_DIV_TRK: begin
        if (div_rsp.done) begin
          trk_nxt     = div_rsp.quot[SEC_W-1:0];
          div_req_nxt = '{start: 1'b1, dividend: DIV_W'(div_rsp.rem), divisor: il_eff};
          state_nxt   = B_DIV_IL;
        end
      end
      B_DIV_IL: begin
        if (div_rsp.done) begin
          grp_nxt   = 13'({6'b0, div_rsp.rem} * {6'b0, cfg.sector_increment})
                      + 13'(div_rsp.quot[5:0]);
          skw_nxt   = DIV_W'(trk_r) * DIV_W'(cfg.track_skew);
          state_nxt = B_SUM;
        end
      end
      B_SUM: begin
        div_req_nxt = '{start: 1'b1, dividend: skw_r + DIV_W'(grp_r), divisor: spt_eff};
        state_nxt   = B_DIV_SEC;
      end
      B_DIV_SEC: begin
        if (div_rsp.done) begin
          vld_nxt   = 1'b1;
          res_nxt   = '{track: trk_r[6:0] + 7'(cfg.track_offset),
                        phys_sector: div_rsp.rem + 6'd1,
                        last: last_r, error: 1'b0};
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= B_IDLE;
      div_req_r.start <= 1'b0;
      vld_r           <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      div_req_r.start <= div_req_nxt.start;
      vld_r           <= vld_nxt;
    end
    div_req_r.dividend <= div_req_nxt.dividend;
    div_req_r.divisor  <= div_req_nxt.divisor;
    trk_r              <= trk_nxt;
    last_r             <= last_nxt;
    grp_r              <= grp_nxt;
    skw_r              <= skw_nxt;
    res_r              <= res_nxt;
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;
  assign busy      = (state_r != B_IDLE);

endmodule

@@ rtl/floppy_sector_interleave_mapper_unit.sv @@
// Top level of the floppy sector interleave mapper: configuration registers,
// front end, job queue and back end. Depends on fsim_pkg and all fsim_* modules.
//
// Usage:
//   Request channel: drive in_req (block number, byte count) and raise start;
//   the request is taken at a rising edge where start is high and busy is low.
//   busy stays high until the cycle that shows the last result of the request.
//   Result channel: each result is shown on out_res for one cycle with
//   out_valid high. The receiver cannot stall; every strobe is one result.
//   A bad block number gives a single result with error and last set.
//   Otherwise one result per 128-byte sector, at least one and at most 64,
//   the final one with last set.
//   Configuration: cfg_we with cfg_addr and cfg_wdata writes one register
//   at the clock edge; write only while busy is low.
//   Mapping: the back end maps a sector with three divider passes (track,
//   group, sector) and pops the next job only once it is back in idle; the
//   front end feeds it one job per cycle while the queue has room. An error
//   job needs no divider pass and gives its result straight away.
//   Reset (rst_n low, synchronous) loads the default geometry and empties
//   the queue and both ends.
module floppy_sector_interleave_mapper_unit import fsim_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  req_t             in_req,
  output logic             busy,
  output logic             out_valid,
  output res_t             out_res,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic front_busy, back_busy;
  logic q_push, q_pop, q_full, q_empty;
  job_t push_job, pop_job;
  logic accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{sectors_per_track: 6'd26, sectors_per_block: 4'd4,
                 total_sectors: 12'd2002, total_blocks: 10'd500,
                 sector_increment: 6'd2, interleave: 6'd13,
                 track_skew: 6'd6, track_offset: 2'd0};
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_SPT:    cfg_r.sectors_per_track <= cfg_wdata[5:0];
        REG_SPB:    cfg_r.sectors_per_block <= cfg_wdata[3:0];
        REG_TSEC:   cfg_r.total_sectors     <= cfg_wdata;
        REG_TBLK:   cfg_r.total_blocks      <= cfg_wdata[9:0];
        REG_INC:    cfg_r.sector_increment  <= cfg_wdata[5:0];
        REG_IL:     cfg_r.interleave        <= cfg_wdata[5:0];
        REG_SKEW:   cfg_r.track_skew        <= cfg_wdata[5:0];
        REG_OFFSET: cfg_r.track_offset      <= cfg_wdata[1:0];
        default:    cfg_r <= cfg_r;
      endcase
    end
  end

  assign accept = start && !busy;
  assign busy   = front_busy || !q_empty || back_busy;

  fsim_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .req    (in_req),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job),
    .busy   (front_busy)
  );

  fsim_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  fsim_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (out_res),
    .busy      (back_busy)
  );

endmodule
